### rtl/core/bft_pkg.sv
package bft_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned SlotW = $clog2(TableEntries);
  localparam int unsigned HitW = 6;

  typedef enum logic [2:0] {
    CMD_LOOKUP = 3'd0,
    CMD_CREATE = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_TOUCH  = 3'd3,
    CMD_SWEEP  = 3'd4
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_IDLE_TIMEOUT     = 1'b0,
    CFG_PROGRESS_TIMEOUT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EXP_NONE   = 2'd0,
    EXP_SILENT = 2'd1,
    EXP_RESET  = 2'd2
  } expire_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_FWD,
    ST_SCAN_REV,
    ST_READ,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] src_ip;
    logic [15:0] src_pt;
    logic [31:0] dst_ip;
    logic [15:0] dst_pt;
    logic [31:0] syn_seq;
    logic [31:0] now;
    logic [5:0]  slot;
    logic        reassembly_busy;
    logic        progress_made;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic        reversed;
    logic        created;
    logic        table_full;
    logic [5:0]  hit_slot;
    logic [31:0] expected_seq;
    logic [1:0]  expire_action;
    logic [31:0] cli_addr;
    logic [15:0] cli_pt;
    logic [31:0] srv_addr;
    logic [15:0] srv_pt;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic             load;      // capture input item, clear scan state
    logic             scan;      // issue key read at scan index
    logic             rev;       // compare swapped key
    logic             restart;   // reset scan index for reverse pass
    logic             read;      // read hit entry (or sweep slot)
    logic             finish;    // compute result and update table
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic last;
    logic is_scan;
    logic is_lookup;
  } dp_stat_t;

endpackage

### rtl/core/bft_ctrl.sv
module bft_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  bft_pkg::dp_stat_t stat_i,
  output bft_pkg::dp_cmd_t  cmd_o
);
  import bft_pkg::*;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d    = state_q;
    ovalid_d   = ovalid_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = stat_i.is_scan ? ST_SCAN_FWD : ST_READ;
        end
      end
      ST_SCAN_FWD: begin
        // compare runs one entry behind the key read
        if (stat_i.hit) begin
          state_d = ST_READ;
        end else if (stat_i.last) begin
          if (stat_i.is_lookup) begin
            cmd_o.restart = 1'b1;
            state_d = ST_SCAN_REV;
          end else begin
            state_d = ST_READ;
          end
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_SCAN_REV: begin
        cmd_o.rev = 1'b1;
        if (stat_i.hit || stat_i.last) state_d = ST_READ;
        else cmd_o.scan = 1'b1;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!ovalid_d) begin
          cmd_o.finish = 1'b1;
          ovalid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/core/bft_dp.sv
module bft_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bft_pkg::in_item_t in_item_i,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  bft_pkg::dp_cmd_t  cmd_i,
  output bft_pkg::dp_stat_t stat_o,
  output bft_pkg::out_item_t out_item_o
);
  import bft_pkg::*;

  // table storage: valid bits in flops, the rest in memories
  logic [TableEntries-1:0] valid_q;
  logic [47:0] key_c_mem [TableEntries];
  logic [47:0] key_s_mem [TableEntries];
  logic [31:0] seq_mem   [TableEntries];
  logic [31:0] seen_mem  [TableEntries];
  logic [31:0] prog_mem  [TableEntries];
  logic        busy_mem  [TableEntries];

  logic [15:0] idle_to_q, prog_to_q;
  in_item_t    it_q;
  logic [SlotW-1:0] idx_q, cidx_q;
  logic        pend_q;
  logic [47:0] kc_q, ks_q;
  logic        hit_q, rev_q, free_ok_q, slot_ok_q;
  logic [SlotW-1:0] hit_idx_q, free_idx_q;
  logic [47:0] rd_c_q, rd_s_q;
  logic [31:0] rd_seq_q, rd_seen_q, rd_prog_q;
  logic        rd_busy_q;
  out_item_t   out_q, out_d;

  logic [47:0] fc, fs, cmp_c, cmp_s;
  logic        cmp_hit;
  logic [31:0] d_seen, d_prog;
  logic        idle_exp, prog_exp;

  assign fc   = {it_q.src_ip, it_q.src_pt};
  assign fs   = {it_q.dst_ip, it_q.dst_pt};
  assign cmp_c = cmd_i.rev ? fs : fc;
  assign cmp_s = cmd_i.rev ? fc : fs;
  // key words arrive in the cycle after their read; pend_q marks them
  assign cmp_hit = pend_q && valid_q[cidx_q] && kc_q == cmp_c && ks_q == cmp_s;

  assign stat_o.hit       = cmp_hit;
  assign stat_o.last      = pend_q && (cidx_q == SlotW'(TableEntries - 1));
  assign stat_o.is_scan   = !(in_item_i.cmd == CMD_SWEEP);
  assign stat_o.is_lookup = (it_q.cmd == CMD_LOOKUP);
  assign out_item_o = out_q;

  // timeout tests on the read-back entry
  assign d_seen   = it_q.now - rd_seen_q;
  assign d_prog   = it_q.now - rd_prog_q;
  assign idle_exp = !rd_busy_q && it_q.now > rd_seen_q && d_seen > {16'd0, idle_to_q};
  assign prog_exp = rd_busy_q && it_q.now > rd_prog_q && d_prog > {16'd0, prog_to_q};

  always_comb begin
    out_d = '0;
    if (it_q.cmd == CMD_CREATE && !hit_q) begin
      if (free_ok_q) begin
        out_d.found        = 1'b1;
        out_d.created      = 1'b1;
        out_d.hit_slot     = HitW'(free_idx_q);
        out_d.expected_seq = it_q.syn_seq + 32'd1;
        out_d.cli_addr     = it_q.src_ip;
        out_d.cli_pt       = it_q.src_pt;
        out_d.srv_addr     = it_q.dst_ip;
        out_d.srv_pt       = it_q.dst_pt;
      end else begin
        out_d.table_full = 1'b1;
      end
    end else if (hit_q && it_q.cmd <= CMD_SWEEP) begin
      out_d.found        = 1'b1;
      out_d.reversed     = rev_q && it_q.cmd == CMD_LOOKUP;
      out_d.hit_slot     = HitW'(hit_idx_q);
      out_d.expected_seq = rd_seq_q + 32'd1;
      out_d.cli_addr     = rd_c_q[47:16];
      out_d.cli_pt       = rd_c_q[15:0];
      out_d.srv_addr     = rd_s_q[47:16];
      out_d.srv_pt       = rd_s_q[15:0];
      if (it_q.cmd == CMD_SWEEP) begin
        if (idle_exp) out_d.expire_action = EXP_SILENT;
        else if (prog_exp) out_d.expire_action = EXP_RESET;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_to_q <= 16'd30;
      prog_to_q <= 16'd10;
      valid_q   <= '0;
      pend_q    <= 1'b0;
    end else begin
      pend_q <= cmd_i.scan;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_IDLE_TIMEOUT:     idle_to_q <= cfg_data_i;
          CFG_PROGRESS_TIMEOUT: prog_to_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.finish) begin
        unique case (it_q.cmd)
          CMD_CREATE:
            if (!hit_q && free_ok_q) valid_q[free_idx_q] <= 1'b1;
          CMD_REMOVE:
            if (hit_q) valid_q[hit_idx_q] <= 1'b0;
          CMD_SWEEP:
            if (out_d.expire_action != EXP_NONE) valid_q[hit_idx_q] <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      it_q      <= in_item_i;
      hit_q     <= 1'b0;
      rev_q     <= 1'b0;
      free_ok_q <= 1'b0;
      free_idx_q <= '0;
      slot_ok_q <= (32'(in_item_i.slot) < 32'(TableEntries));
      hit_idx_q <= SlotW'(in_item_i.slot);
    end
    if (cmd_i.load || cmd_i.restart) idx_q <= '0;
    else if (cmd_i.scan) idx_q <= idx_q + SlotW'(1);
    if (cmd_i.scan) begin
      kc_q   <= key_c_mem[idx_q];
      ks_q   <= key_s_mem[idx_q];
      cidx_q <= idx_q;
    end
    if (pend_q) begin
      if (cmp_hit) begin
        hit_q     <= 1'b1;
        rev_q     <= cmd_i.rev;
        hit_idx_q <= cidx_q;
      end
      if (!valid_q[cidx_q] && !free_ok_q && !cmd_i.rev) begin
        free_ok_q  <= 1'b1;
        free_idx_q <= cidx_q;
      end
    end
    if (cmd_i.read) begin
      if (it_q.cmd == CMD_SWEEP) hit_q <= slot_ok_q && valid_q[hit_idx_q];
      rd_c_q    <= key_c_mem[hit_idx_q];
      rd_s_q    <= key_s_mem[hit_idx_q];
      rd_seq_q  <= seq_mem[hit_idx_q];
      rd_seen_q <= seen_mem[hit_idx_q];
      rd_prog_q <= prog_mem[hit_idx_q];
      rd_busy_q <= busy_mem[hit_idx_q];
    end
    if (cmd_i.finish) begin
      out_q <= out_d;
      if (it_q.cmd == CMD_CREATE && !hit_q && free_ok_q) begin
        key_c_mem[free_idx_q] <= fc;
        key_s_mem[free_idx_q] <= fs;
        seq_mem[free_idx_q]   <= it_q.syn_seq;
        seen_mem[free_idx_q]  <= it_q.now;
        prog_mem[free_idx_q]  <= it_q.now;
        busy_mem[free_idx_q]  <= 1'b0;
      end
      if (it_q.cmd == CMD_TOUCH && hit_q) begin
        seen_mem[hit_idx_q] <= it_q.now;
        busy_mem[hit_idx_q] <= it_q.reassembly_busy;
        if (it_q.progress_made) prog_mem[hit_idx_q] <= it_q.now;
      end
    end
  end

endmodule

### rtl/core/bidirectional_flow_table_core.sv
// Channel  Signals                           Direction
// in       in_valid_i / in_stall_o / in_item_i   into the block
// out      out_valid_o / out_stall_i / out_item_o out of the block
// cfg      cfg_we_i / cfg_idx_i / cfg_data_i     register writes
//
// Lookup walks the table forward, then reverse (one key comparator; each walk
// primes the key read first); create/remove/touch and unknown commands walk
// forward only, and sweep reads its slot with no walk.
// A hit ends the walk early. Reset is asynchronous, active low; it clears all
// valid bits, no clearing pass.
// The result sits in an output register; a stalled result holds the next item
// in its final state until taken.
module bidirectional_flow_table_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  bft_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output bft_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import bft_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  bft_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .stat_i (dstat),
    .cmd_o  (dcmd)
  );

  bft_dp u_dp (
    .clk_i,
    .rst_ni,
    .in_item_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cmd_i      (dcmd),
    .stat_o     (dstat),
    .out_item_o
  );

endmodule

### verif/bidirectional_flow_table_core_tb.sv
module bidirectional_flow_table_core_tb;
  import bft_pkg::*;

  localparam int unsigned NumFlows = 64;
  localparam int unsigned RandItems = 1700;

  // Shadow copy of the flow table, kept in step with every accepted item.
  class flow_table_sb;
    bit          valid_q [NumFlows];
    logic [31:0] cip [NumFlows];
    logic [15:0] cport [NumFlows];
    logic [31:0] sip [NumFlows];
    logic [15:0] sport [NumFlows];
    logic [31:0] syn [NumFlows];
    logic [31:0] seen [NumFlows];
    logic [31:0] prog [NumFlows];
    bit          busy [NumFlows];
    logic [15:0] idle_to;
    logic [15:0] prog_to;
    out_item_t   pending_q[$];
    int          errors;

    function new();
      idle_to = 16'd30;
      prog_to = 16'd10;
      errors = 0;
      foreach (valid_q[i]) valid_q[i] = 1'b0;
    endfunction

    function int find_flow(logic [31:0] cip_v, logic [15:0] cp_v,
                           logic [31:0] sip_v, logic [15:0] sp_v);
      for (int i = 0; i < NumFlows; i++)
        if (valid_q[i] && cip[i] == cip_v && cport[i] == cp_v &&
            sip[i] == sip_v && sport[i] == sp_v) return i;
      return -1;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (valid_q[i]) n += valid_q[i];
      return n;
    endfunction

    function out_item_t entry_view(int i);
      out_item_t r;
      r = '0;
      r.found = 1'b1;
      r.hit_slot = i[5:0];
      r.expected_seq = syn[i] + 32'd1;
      r.cli_addr = cip[i];
      r.cli_pt = cport[i];
      r.srv_addr = sip[i];
      r.srv_pt = sport[i];
      return r;
    endfunction

    // Works out the result of one accepted item and queues it.
    function void note_item(in_item_t it);
      out_item_t r;
      int i;
      r = '0;
      case (it.cmd)
        CMD_LOOKUP: begin
          i = find_flow(it.src_ip, it.src_pt, it.dst_ip, it.dst_pt);
          if (i >= 0) r = entry_view(i);
          else begin
            i = find_flow(it.dst_ip, it.dst_pt, it.src_ip, it.src_pt);
            if (i >= 0) begin
              r = entry_view(i);
              r.reversed = 1'b1;
            end
          end
        end
        CMD_CREATE: begin
          i = find_flow(it.src_ip, it.src_pt, it.dst_ip, it.dst_pt);
          if (i >= 0) r = entry_view(i);
          else begin
            for (i = 0; i < NumFlows; i++) if (!valid_q[i]) break;
            if (i >= NumFlows) r.table_full = 1'b1;
            else begin
              valid_q[i] = 1'b1;
              cip[i] = it.src_ip;
              cport[i] = it.src_pt;
              sip[i] = it.dst_ip;
              sport[i] = it.dst_pt;
              syn[i] = it.syn_seq;
              seen[i] = it.now;
              prog[i] = it.now;
              busy[i] = 1'b0;
              r = entry_view(i);
              r.created = 1'b1;
            end
          end
        end
        CMD_REMOVE: begin
          i = find_flow(it.src_ip, it.src_pt, it.dst_ip, it.dst_pt);
          if (i >= 0) begin
            r = entry_view(i);
            valid_q[i] = 1'b0;
          end
        end
        CMD_TOUCH: begin
          i = find_flow(it.src_ip, it.src_pt, it.dst_ip, it.dst_pt);
          if (i >= 0) begin
            seen[i] = it.now;
            busy[i] = it.reassembly_busy;
            if (it.progress_made) prog[i] = it.now;
            r = entry_view(i);
          end
        end
        CMD_SWEEP: begin
          i = int'(it.slot);
          if (i < NumFlows && valid_q[i]) begin
            r = entry_view(i);
            // idle test first, then the progress test
            if (!busy[i] && it.now > seen[i] && (it.now - seen[i]) > {16'd0, idle_to}) begin
              r.expire_action = EXP_SILENT;
              valid_q[i] = 1'b0;
            end else if (busy[i] && it.now > prog[i] &&
                         (it.now - prog[i]) > {16'd0, prog_to}) begin
              r.expire_action = EXP_RESET;
              valid_q[i] = 1'b0;
            end
          end
        end
        default: ;
      endcase
      pending_q = {pending_q, r};
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.found !== exp_r.found || got.reversed !== exp_r.reversed ||
          got.created !== exp_r.created || got.table_full !== exp_r.table_full ||
          got.hit_slot !== exp_r.hit_slot || got.expected_seq !== exp_r.expected_seq ||
          got.expire_action !== exp_r.expire_action ||
          got.cli_addr !== exp_r.cli_addr || got.cli_pt !== exp_r.cli_pt ||
          got.srv_addr !== exp_r.srv_addr || got.srv_pt !== exp_r.srv_pt) begin
        $display("%0t: result mismatch expected %h actual %h", $time, exp_r, got);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_we_i = 1'b0;
  logic      cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  flow_table_sb sb = new();
  bit quiet_tail = 1'b0;  // no idling or stalls near the end
  bit done_flag = 1'b0;

  // Pool of flow endpoints so that keys repeat and flows get hit again.
  logic [31:0] ip_pool [8];
  logic [15:0] port_pool [8];
  logic [31:0] clock_now = 32'd1000;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  bidirectional_flow_table_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Result monitor: every accepted result is checked against the oldest one owed.
  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_item_o);

  // Receiver stalls in random bursts.
  initial begin
    int n;
    @(posedge rst_ni);
    while (!done_flag) begin
      n = $urandom_range(1, 11);
      if (!quiet_tail && $urandom_range(0, 2) == 0) out_stall_i <= 1'b1;
      else out_stall_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    out_stall_i <= 1'b0;
  end

  // Present one item and hold it until accepted; the expectation is noted on acceptance.
  task automatic send_item(in_item_t it);
    int gap;
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IDLE_TIMEOUT) sb.idle_to = val;
    else sb.prog_to = val;
  endtask

  function automatic in_item_t noise_item();
    logic [191:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t flow_item(cmd_e c, int ci, int si);
    in_item_t it;
    it = '0;
    it.cmd = c;
    it.src_ip = ip_pool[ci];
    it.src_pt = port_pool[ci];
    it.dst_ip = ip_pool[si];
    it.dst_pt = port_pool[si];
    it.syn_seq = $urandom();
    it.now = clock_now;
    it.slot = 6'($urandom_range(0, 63));
    it.reassembly_busy = 1'($urandom_range(0, 1));
    it.progress_made = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Mostly well-formed traffic over pooled endpoints, with some fully random noise.
  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      it = noise_item();
      return it;
    end
    it = flow_item(cmd_e'(3'($urandom_range(0, 4))), $urandom_range(0, 7),
                   $urandom_range(0, 7));
    if (pick < 28) it.cmd = CMD_CREATE;
    else if (pick < 34) it.cmd = CMD_SWEEP;
    if (it.cmd == CMD_SWEEP && sb.occupancy() > 0)
      it.slot = 6'($urandom_range(0, 63));
    // time moves forward mostly, sometimes backward to hit the ordering rule
    if ($urandom_range(0, 15) == 0) it.now = clock_now - $urandom_range(0, 50);
    else it.now = clock_now;
    return it;
  endfunction

  initial begin
    in_item_t it;
    int timeouts[4][2];
    timeouts = '{'{30, 10}, '{0, 0}, '{65535, 65535}, '{5, 20}};
    for (int i = 0; i < 8; i++) begin
      ip_pool[i] = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom();
      port_pool[i] = (i == 0) ? 16'h0 : (i == 1) ? 16'hFFFF : 16'($urandom());
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: create, forward and reverse lookup, touch, both expiry kinds,
    // misses, unknown commands, out-of-range times.
    it = flow_item(CMD_CREATE, 0, 1); it.syn_seq = 32'hFFFF_FFFF; send_item(it);
    it = flow_item(CMD_CREATE, 2, 3); it.syn_seq = 32'h0; send_item(it);
    it = flow_item(CMD_CREATE, 0, 1); send_item(it);               // already present
    send_item(flow_item(CMD_LOOKUP, 0, 1));
    send_item(flow_item(CMD_LOOKUP, 1, 0));                        // reverse hit
    send_item(flow_item(CMD_LOOKUP, 4, 5));                        // miss
    send_item(flow_item(CMD_TOUCH, 4, 5));                         // miss
    send_item(flow_item(CMD_REMOVE, 4, 5));                        // miss
    it = flow_item(CMD_TOUCH, 2, 3); it.reassembly_busy = 1'b1; it.progress_made = 1'b1;
    send_item(it);
    it = flow_item(CMD_SWEEP, 0, 0); it.slot = 6'd0; it.now = clock_now + 30; send_item(it);
    it.now = clock_now + 31; send_item(it);                        // silent expiry
    it.slot = 6'd1; it.now = clock_now + 10; send_item(it);
    it.now = clock_now - 1; send_item(it);                         // time went backward
    it.now = clock_now + 11; send_item(it);                        // reset expiry
    it.slot = 6'd63; send_item(it);                                // invalid slot
    for (int c = 5; c < 8; c++) begin
      it = noise_item();
      it.cmd = c[2:0];
      send_item(it);
    end
    it = flow_item(CMD_CREATE, 5, 6); it.now = 32'hFFFF_FFFF; send_item(it);
    send_item(flow_item(CMD_REMOVE, 5, 6));
    it = flow_item(CMD_SWEEP, 0, 0); it.slot = 6'd0; it.now = 32'h0; send_item(it);

    // Fill the table to reach the full case, then sweep it empty.
    for (int i = 0; i < NumFlows + 2; i++) begin
      it = flow_item(CMD_CREATE, 0, 1);
      it.src_ip = 32'hA000_0000 + i;
      send_item(it);
    end
    for (int i = 0; i < NumFlows; i++) begin
      it = flow_item(CMD_SWEEP, 0, 0);
      it.slot = 6'(i);
      it.now = 32'hFFFF_FFFF;
      send_item(it);
    end

    // Random phases under different timeout settings.
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      write_reg(CFG_IDLE_TIMEOUT, 16'(timeouts[ph][0]));
      write_reg(CFG_PROGRESS_TIMEOUT, 16'(timeouts[ph][1]));
      for (int n = 0; n < RandItems / 4; n++) begin
        if (ph == 3 && n > RandItems / 4 - 60) quiet_tail = 1'b1;
        if ($urandom_range(0, 3) == 0) clock_now += $urandom_range(0, 12);
        send_item(random_item());
      end
    end
    drain_results();
    done_flag = 1'b1;
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### bidirectional_flow_table_core.f
rtl/core/bft_pkg.sv
rtl/core/bft_ctrl.sv
rtl/core/bft_dp.sv
rtl/core/bidirectional_flow_table_core.sv
verif/bidirectional_flow_table_core_tb.sv
